// ----- rtl/mrgr_pkg.sv -----
// ----------------------------------------------------------------------------
// mrgr_pkg: shared types and constants for the grant/release table
// Sizes, register map, reset values, operation codes and the result type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mrgr_pkg;

  localparam int CLIENTS    = 5;
  localparam int RESOURCES  = 3;
  localparam int COUNT_BITS = 8;

  localparam int MAX_CLIENTS   = 5;
  localparam int MAX_RESOURCES = 3;
  localparam int COUNT_MAX     = (1 << COUNT_BITS) - 1;

  localparam int BYTE_W    = 8;
  localparam int CLAIM_W   = BYTE_W * MAX_RESOURCES;
  localparam int CLIENT_W  = 3;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = CLAIM_W;

  localparam int CLAIM_SEL_W = $clog2(MAX_CLIENTS);
  localparam int RES_SEL_W   = $clog2(MAX_RESOURCES);

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL0 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CLAIM0 = CFG_IDX_W'(MAX_RESOURCES);
  localparam logic [CFG_IDX_W-1:0] REG_END    = CFG_IDX_W'(MAX_RESOURCES + MAX_CLIENTS);

  localparam logic [BYTE_W-1:0] TOTAL_RESET [MAX_RESOURCES] = '{8'd10, 8'd5, 8'd7};
  localparam logic [CLAIM_W-1:0] CLAIM_RESET [MAX_CLIENTS] = '{
    24'h030507, 24'h020203, 24'h020009, 24'h020202, 24'h030304
  };

  typedef enum logic {
    MODE_REQUEST = 1'b0,
    MODE_RELEASE = 1'b1
  } mode_e;

  typedef logic [COUNT_BITS-1:0] count_t;

  typedef struct packed {
    logic                 en;
    logic [RES_SEL_W-1:0] sel;
    count_t               value;
  } free_load_t;

  typedef struct packed {
    logic [MAX_RESOURCES-1:0][BYTE_W-1:0] free;
    logic                                 all_finished;
    logic                                 granted;
  } result_t;

  function automatic count_t clip_byte(input logic [BYTE_W-1:0] b);
    count_t r;
    if (int'(b) > COUNT_MAX) begin
      r = count_t'(COUNT_MAX);
    end else begin
      r = count_t'(b);
    end
    return r;
  endfunction

endpackage

// ----- rtl/mrgr_alloc.sv -----
// ----------------------------------------------------------------------------
// mrgr_alloc: allocation state and combinational grant/release step
// Holds free counts, held units and finished marks; computes one step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mrgr_alloc (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  step_i,
  input  logic                                  mode_i,
  input  logic [mrgr_pkg::CLIENT_W-1:0]         client_i,
  input  logic [mrgr_pkg::CLIENTS-1:0][mrgr_pkg::CLAIM_W-1:0] claims_i,
  input  mrgr_pkg::free_load_t                  load_i,
  output mrgr_pkg::result_t                     res_o
);
  import mrgr_pkg::*;

  logic [RESOURCES-1:0][COUNT_BITS-1:0]              free_q, free_d;
  logic [CLIENTS-1:0][RESOURCES-1:0][COUNT_BITS-1:0] held_q, held_d;
  logic [CLIENTS-1:0]                                fin_q, fin_d;

  logic                          client_ok;
  logic                          fits;
  logic [CLAIM_W-1:0]            claim_sel;
  logic [RESOURCES-1:0][COUNT_BITS-1:0] held_sel;
  logic [RESOURCES-1:0][COUNT_BITS-1:0] need;
  count_t                        claim_k;
  logic [COUNT_BITS:0]           sum;

  always_comb begin
    client_ok = 1'b0;
    claim_sel = '0;
    held_sel  = '0;
    for (int c = 0; c < CLIENTS; c++) begin
      if (client_i == CLIENT_W'(c)) begin
        client_ok = 1'b1;
        claim_sel = claims_i[c];
        held_sel  = held_q[c];
      end
    end

    fits = 1'b1;
    for (int k = 0; k < RESOURCES; k++) begin
      claim_k = clip_byte(claim_sel[BYTE_W*k +: BYTE_W]);
      need[k] = (claim_k > held_sel[k]) ? claim_k - held_sel[k] : '0;
      if (need[k] > free_q[k]) begin
        fits = 1'b0;
      end
    end

    free_d      = free_q;
    held_d      = held_q;
    fin_d       = fin_q;
    res_o       = '0;
    sum         = '0;

    if (step_i && client_ok) begin
      for (int c = 0; c < CLIENTS; c++) begin
        if (client_i == CLIENT_W'(c)) begin
          if (mode_i == MODE_REQUEST) begin
            if (fits) begin
              for (int k = 0; k < RESOURCES; k++) begin
                free_d[k]    = free_q[k] - need[k];
                sum          = {1'b0, held_q[c][k]} + {1'b0, need[k]};
                held_d[c][k] = (int'(sum) > COUNT_MAX) ? count_t'(COUNT_MAX)
                                                       : sum[COUNT_BITS-1:0];
              end
              fin_d[c]      = 1'b1;
              res_o.granted = 1'b1;
            end
          end else begin
            for (int k = 0; k < RESOURCES; k++) begin
              sum          = {1'b0, free_q[k]} + {1'b0, held_q[c][k]};
              free_d[k]    = (int'(sum) > COUNT_MAX) ? count_t'(COUNT_MAX)
                                                     : sum[COUNT_BITS-1:0];
              held_d[c][k] = '0;
            end
            fin_d[c] = 1'b0;
          end
        end
      end
    end

    if (load_i.en && int'(load_i.sel) < RESOURCES) begin
      for (int k = 0; k < RESOURCES; k++) begin
        if (load_i.sel == RES_SEL_W'(k)) begin
          free_d[k] = load_i.value;
        end
      end
    end

    res_o.all_finished = &fin_d;
    for (int k = 0; k < RESOURCES; k++) begin
      res_o.free[k] = BYTE_W'(free_d[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < RESOURCES; k++) begin
        free_q[k] <= clip_byte(TOTAL_RESET[k]);
      end
      held_q <= '0;
      fin_q  <= '0;
    end else begin
      free_q <= free_d;
      held_q <= held_d;
      fin_q  <= fin_d;
    end
  end

`ifndef SYNTHESIS
  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!step_i && !load_i.en) |=> ($stable(free_q) && $stable(held_q) && $stable(fin_q)))
    else $error("allocation state changed without a step or load");

  a_grant_no_gain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && !load_i.en && res_o.granted) |=> (free_q[0] <= $past(free_q[0])))
    else $error("grant increased a free count");

  a_release_no_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && !load_i.en && mode_i == MODE_RELEASE) |=> (free_q[0] >= $past(free_q[0])))
    else $error("release decreased a free count");

  a_release_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && mode_i == MODE_RELEASE) |-> (!res_o.granted && !fin_d[0] ||
                                            client_i != CLIENT_W'(0)))
    else $error("release of client zero granted or left it finished");
`endif

endmodule

// ----- rtl/multi_resource_grant_release.sv -----
// ----------------------------------------------------------------------------
// multi_resource_grant_release: grant/release table for shared resources
// Takes one request or release per cycle while the result output is not
// held back, and returns the grant decision, the all-finished flag and the
// free counts after the step. The step uses one input register and one
// result register; the free counts, held units and finished marks update in
// the same cycle as the step, so the next item can step in the following
// cycle unless the result output stalls. The result is held in its register
// until it transfers out. A result waiting on the output does not block one
// more input transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_resource_grant_release (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // config write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mrgr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [mrgr_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // input stream
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [7:0]                        s_axis_tdata_i,  // [2:0] client_index
  input  logic [0:0]                        s_axis_tuser_i,  // [0] mode
  // result stream
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [31:0]                       m_axis_tdata_o   // [0] granted,
                                                             // [1] all_finished,
                                                             // [9:2] free_r0,
                                                             // [17:10] free_r1,
                                                             // [25:18] free_r2
);
  import mrgr_pkg::*;

  logic [CLIENTS-1:0][CLAIM_W-1:0] claims_q;
  logic [CLAIM_SEL_W-1:0]          claim_sel;
  logic                            cfg_xfer;
  free_load_t                      load;

  logic                in_vld_q;
  logic                mode_q;
  logic [CLIENT_W-1:0] client_q;
  logic                out_vld_q;
  result_t             out_q;
  result_t             res;
  logic                advance;
  logic                step;
  logic                in_xfer;

  assign cfg_ready_o = 1'b1;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;
  assign claim_sel   = CLAIM_SEL_W'(cfg_index_i - REG_CLAIM0);

  assign load.en    = cfg_xfer && (cfg_index_i < REG_CLAIM0);
  assign load.sel   = RES_SEL_W'(cfg_index_i - REG_TOTAL0);
  assign load.value = clip_byte(cfg_data_i[BYTE_W-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CLIENTS; c++) begin
        claims_q[c] <= CLAIM_RESET[c];
      end
    end else if (cfg_xfer && cfg_index_i >= REG_CLAIM0 && cfg_index_i < REG_END) begin
      for (int c = 0; c < CLIENTS; c++) begin
        if (claim_sel == CLAIM_SEL_W'(c)) begin
          claims_q[c] <= cfg_data_i;
        end
      end
    end
  end

  assign advance         = !out_vld_q || m_axis_tready_i;
  assign step            = in_vld_q && advance;
  assign s_axis_tready_o = !in_vld_q || advance;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  mrgr_alloc u_alloc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .mode_i   (mode_q),
    .client_i (client_q),
    .claims_i (claims_q),
    .load_i   (load),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (step) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      mode_q   <= s_axis_tuser_i[0];
      client_q <= s_axis_tdata_i[CLIENT_W-1:0];
    end
    if (step) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = 32'(out_q);

endmodule
